// File: rtl/core/url_percent_encoder_utf8_defines.svh
// assertion macros shared by the encoder modules
`ifndef URL_PERCENT_ENCODER_UTF8_DEFINES_SVH
`define URL_PERCENT_ENCODER_UTF8_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UPE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define UPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/upe_pkg.sv
package upe_pkg;

    localparam int CP_W      = 32;
    localparam int CHAR_W    = 7;
    localparam int MAX_BYTES = 4;
    localparam int NB_W      = $clog2(MAX_BYTES);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [CHAR_W-1:0] CH_PCT   = 7'h25;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A_OFS = 7'h57;

    typedef struct packed {
        logic                        pass;
        logic [NB_W-1:0]             nbytes_m1;
        logic [MAX_BYTES-1:0][7:0]   bytes;
    } upe_desc_t;

    typedef struct packed {
        logic      push;
        upe_desc_t desc;
    } upe_push_t;

    typedef struct packed {
        logic      valid;
        logic      full;
        upe_desc_t desc;
    } upe_head_t;

    function automatic logic is_pass(input logic [CP_W-1:0] c);
        logic r;
        r = (c >= 32'h30 && c <= 32'h39) || (c >= 32'h41 && c <= 32'h5a) ||
            (c >= 32'h61 && c <= 32'h7a) || c == 32'h2d || c == 32'h5f ||
            c == 32'h2e || c == 32'h7e;
        return r;
    endfunction

    function automatic logic is_dropped(input logic [CP_W-1:0] c);
        logic r;
        r = (c > 32'h10ffff) || (c[15:1] == 15'h7fff) ||
            (c >= 32'hd800 && c <= 32'hdfff) || (c >= 32'hfdd0 && c <= 32'hfdef);
        return r;
    endfunction

    function automatic upe_desc_t encode(input logic [CP_W-1:0] c);
        upe_desc_t d;
        d.pass  = is_pass(c);
        d.bytes = '0;
        if (c <= 32'h7f)
        begin
            d.nbytes_m1 = NB_W'(0);
            d.bytes[0]  = c[7:0];
        end
        else if (c <= 32'h7ff)
        begin
            d.nbytes_m1 = NB_W'(1);
            d.bytes[0]  = {3'b110, c[10:6]};
            d.bytes[1]  = {2'b10, c[5:0]};
        end
        else if (c <= 32'hffff)
        begin
            d.nbytes_m1 = NB_W'(2);
            d.bytes[0]  = {4'b1110, c[15:12]};
            d.bytes[1]  = {2'b10, c[11:6]};
            d.bytes[2]  = {2'b10, c[5:0]};
        end
        else
        begin
            d.nbytes_m1 = NB_W'(3);
            d.bytes[0]  = {5'b11110, c[20:18]};
            d.bytes[1]  = {2'b10, c[17:12]};
            d.bytes[2]  = {2'b10, c[11:6]};
            d.bytes[3]  = {2'b10, c[5:0]};
        end
        return d;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
        logic [CHAR_W-1:0] r;
        if (n < 4'd10)
            r = CH_ZERO + CHAR_W'(n);
        else
            r = CH_A_OFS + CHAR_W'(n);
        return r;
    endfunction

endpackage

// File: rtl/core/upe_in_if.sv
interface upe_in_if import upe_pkg::*;;
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

// File: rtl/core/upe_out_if.sv
interface upe_out_if import upe_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// File: rtl/core/url_percent_encoder_utf8.sv
// URL percent encoder: takes one Unicode code point per transaction on code_in and
// returns its URL-encoded form on char_out, one ASCII character per transaction, with
// last_of_run set on the final character of each code point. Unreserved characters
// pass through as one character; invalid code points (above U+10FFFF, surrogates,
// noncharacters) are consumed and produce nothing; all others become one to four
// UTF-8 bytes, each sent as '%' and two lowercase hex digits. A two-entry queue
// separates input classification from the output serializer, so input keeps flowing
// while the output stalls until the queue is full. The serializer emits one character
// per cycle while char_out is ready, 1, 3, 6, 9 or 12 characters per code point;
// passthrough code points sustain one transaction per cycle while char_out is ready,
// dropped ones while the queue is not full.
module url_percent_encoder_utf8
    import upe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    upe_in_if.sink    code_in,
    upe_out_if.source char_out
);

    upe_push_t push;
    upe_head_t head;
    logic      pop;

    upe_front u_front
    (
        .code_in (code_in),
        .head    (head),
        .push    (push)
    );

    upe_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head)
    );

    upe_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .char_out (char_out)
    );

endmodule

// File: rtl/core/upe_front.sv
module upe_front
    import upe_pkg::*;
(
    upe_in_if.sink    code_in,
    input  upe_head_t head,
    output upe_push_t push
);

    logic take;

    assign code_in.ready = !head.full;
    assign take          = code_in.valid && code_in.ready;

    // invalid code points are consumed without a queue entry
    assign push.push = take && !is_dropped(code_in.code_point);
    assign push.desc = encode(code_in.code_point);

endmodule

// File: rtl/core/upe_queue.sv
`include "url_percent_encoder_utf8_defines.svh"

module upe_queue
    import upe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  upe_push_t push,
    input  logic      pop,
    output upe_head_t head
);

    upe_desc_t         entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign head.valid = count_reg != '0;
    assign head.full  = count_reg == (QPTR_W+1)'(QDEPTH);
    assign head.desc  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push.push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push.push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
            entries_reg[wr_ptr_reg] <= push.desc;
    end

    `UPE_ASSERT_NOW(a_no_push_full, clk, rst_n, push.push, !head.full || pop, "push into full queue")
    `UPE_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, head.valid, "pop from empty queue")
    `UPE_ASSERT_NEXT(a_count_up, clk, rst_n, push.push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow")

endmodule

// File: rtl/core/upe_back.sv
`include "url_percent_encoder_utf8_defines.svh"

module upe_back
    import upe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  upe_head_t head,
    output logic      pop,
    upe_out_if.source char_out
);

    typedef enum logic [1:0] {PH_PCT, PH_HI, PH_LO} phase_t;

    phase_t            phase_reg, phase_next;
    logic [NB_W-1:0]   idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic              load;
    logic              emit;
    logic              is_last;
    logic [7:0]        cur_byte;
    logic [CHAR_W-1:0] cur_char;

    assign load     = !out_valid_reg || char_out.ready;
    assign emit     = load && head.valid;
    assign cur_byte = head.desc.bytes[idx_reg];
    assign is_last  = head.desc.pass || (phase_reg == PH_LO && idx_reg == head.desc.nbytes_m1);
    assign pop      = emit && is_last;

    always_comb
    begin
        unique case (phase_reg)
            PH_PCT:  cur_char = CH_PCT;
            PH_HI:   cur_char = hex_char(cur_byte[7:4]);
            PH_LO:   cur_char = hex_char(cur_byte[3:0]);
            default: cur_char = CH_PCT;
        endcase
        if (head.desc.pass)
            cur_char = head.desc.bytes[0][CHAR_W-1:0];
    end

    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = cur_char;
            out_last_next  = is_last;
            if (is_last)
            begin
                phase_next = PH_PCT;
                idx_next   = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_PCT:  phase_next = PH_HI;
                    PH_HI:   phase_next = PH_LO;
                    PH_LO:
                    begin
                        phase_next = PH_PCT;
                        idx_next   = idx_reg + 1'b1;
                    end
                    default: phase_next = PH_PCT;
                endcase
            end
        end
        else if (load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PCT;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign char_out.valid       = out_valid_reg;
    assign char_out.out_char    = out_char_reg;
    assign char_out.last_of_run = out_last_reg;

    `UPE_ASSERT_NEXT(a_pop_last, clk, rst_n, pop, out_valid_reg && out_last_reg, "pop without last character")
    `UPE_ASSERT_NEXT(a_pop_rewind, clk, rst_n, pop, phase_reg == PH_PCT && idx_reg == '0, "counters not rewound after pop")
    `UPE_ASSERT_NOW(a_idx_range, clk, rst_n, head.valid, idx_reg <= head.desc.nbytes_m1, "byte index past encoding length")

endmodule
